@@ design/ghrg_pkg.sv @@
// Shared types, codes and tables for the gesture hold/release gate.
// Used by ghrg_span_cmp and gesture_hold_release_gate_top; depends on nothing.
package ghrg_pkg;

  localparam int SHAPE_CODES_DEF = 8;
  localparam int STATE_COUNT_DEF = 12;

  localparam int SHAPE_W = 3;
  localparam int STATE_W = 4;
  localparam int TIME_W  = 32;
  localparam int SPAN_W  = 16;
  localparam int MASK_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] RUN_LEN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_FEED    = 2'd1,
    FUNC_TAKE    = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SCORE    = 3'd0,
    REG_MIN_PALM     = 3'd1,
    REG_RELEASE_MS   = 3'd2,
    REG_SETTLE_MS    = 3'd3,
    REG_RUN_MS       = 3'd4,
    REG_RUN_RESULTS  = 3'd5,
    REG_LONG_HOLD_MS = 3'd6,
    REG_THUMBS_UP    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_THROW   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [SHAPE_W-1:0] shape;
    logic [7:0]         score;
    logic [9:0]         palm_px;
    logic [STATE_W-1:0] state_index;
    logic [TIME_W-1:0]  now_ms;
  } in_req_t;

  typedef struct packed {
    logic [SHAPE_W-1:0] accepted;
    logic [MASK_W-1:0]  blocked_mask;
  } out_res_t;

  // States that also accept a long thumbs-up hold: greeting, post game,
  // story prompt, post story.
  localparam logic [15:0] LONG_HOLD_STATES = 16'b0000_0010_1100_0100;

  function automatic mode_t mode_of(logic [STATE_W-1:0] st);
    mode_t m;
    case (st)
      4'd1, 4'd2, 4'd6, 4'd7, 4'd9: m = MODE_RELEASE;
      4'd4:                         m = MODE_THROW;
      default:                      m = MODE_NONE;
    endcase
    return m;
  endfunction

endpackage

@@ design/ghrg_span_cmp.sv @@
// Shared elapsed-time compare: wrapping span from a timestamp to now,
// tested against a 16-bit limit. Depends on ghrg_pkg.
module ghrg_span_cmp (
  input  logic [ghrg_pkg::TIME_W-1:0] from_ms,
  input  logic [ghrg_pkg::TIME_W-1:0] now_ms,
  input  logic [ghrg_pkg::SPAN_W-1:0] limit_ms,
  output logic                        reached
);
  import ghrg_pkg::*;

  logic [TIME_W-1:0] span;

  // Span is taken modulo 2^32, so a plain subtract handles the wrap.
  assign span    = now_ms - from_ms;
  assign reached = span >= {{(TIME_W-SPAN_W){1'b0}}, limit_ms};

endmodule

@@ design/gesture_hold_release_gate_top.sv @@
// Gesture hold/release gate: top level with sequencer, timers and registers.
// Depends on ghrg_pkg and ghrg_span_cmp.
//
// Requests on in_valid/in_stall/in_data: restart, feed or take. Each gives one
// result on out_valid/out_stall/out_data: the accepted shape (take only, else
// zero) and the mask of shapes whose release latch is still clear. Write
// cfg_wr_en/cfg_index/cfg_wdata only while the gate is idle.
//
// One 32-bit subtract-and-compare unit does every span test in turn. Restart
// and the unused code go straight to the done state; take runs the settle, run
// and long-hold tests; feed checks one release timer per cycle, NT being the
// smaller of SHAPE_CODES and 8 (8 by default). in_stall is high while a request
// is being worked on, so a new request is taken only after the last one has
// left the done state.
//
// rst_n (synchronous, active low) restores the register defaults, zeroes all
// timestamps, clears every release latch and empties the output. While
// out_stall is high the result holds; a finished request waits in the done
// state, with the input stalled, until the output register is free.
module gesture_hold_release_gate_top #(
  parameter int SHAPE_CODES = ghrg_pkg::SHAPE_CODES_DEF,
  parameter int STATE_COUNT = ghrg_pkg::STATE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ghrg_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ghrg_pkg::out_res_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [ghrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ghrg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ghrg_pkg::*;

  // Only shapes below 8 can ever be fed or reported, so timers stop there.
  localparam int NT    = (SHAPE_CODES < MASK_W) ? SHAPE_CODES : MASK_W;
  localparam int IDX_W = $clog2(NT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FEED,
    S_TAKE,
    S_DONE
  } seq_t;

  // Configuration registers
  logic [7:0]        min_score_r,    min_score_nxt;
  logic [9:0]        min_palm_r,     min_palm_nxt;
  logic [SPAN_W-1:0] release_ms_r,   release_ms_nxt;
  logic [SPAN_W-1:0] settle_ms_r,    settle_ms_nxt;
  logic [SPAN_W-1:0] run_ms_r,       run_ms_nxt;
  logic [7:0]        run_results_r,  run_results_nxt;
  logic [SPAN_W-1:0] long_hold_ms_r, long_hold_ms_nxt;
  logic [SHAPE_W-1:0] thumbs_up_r,   thumbs_up_nxt;

  // Gate state
  logic [TIME_W-1:0]  state_start_r, state_start_nxt;
  logic [TIME_W-1:0]  absent_since_r [NT];
  logic [TIME_W-1:0]  absent_since_nxt [NT];
  logic [NT-1:0]      released_r,    released_nxt;
  logic [TIME_W-1:0]  held_since_r,  held_since_nxt;
  logic [SHAPE_W-1:0] held_code_r,   held_code_nxt;
  logic [SHAPE_W-1:0] run_code_r,    run_code_nxt;
  logic [7:0]         run_len_r,     run_len_nxt;
  logic [TIME_W-1:0]  run_start_r,   run_start_nxt;

  // Sequencer and per-request working registers
  seq_t               seq_r,         seq_nxt;
  logic [IDX_W-1:0]   idx_r,         idx_nxt;
  logic [1:0]         step_r,        step_nxt;
  logic [SHAPE_W-1:0] shape_q_r,     shape_q_nxt;
  logic [STATE_W-1:0] st_q_r,        st_q_nxt;
  logic [TIME_W-1:0]  now_q_r,       now_q_nxt;
  logic               settle_ok_r,   settle_ok_nxt;
  logic               run_ok_r,      run_ok_nxt;
  logic [SHAPE_W-1:0] acc_r,         acc_nxt;
  logic               out_valid_r,   out_valid_nxt;
  out_res_t           out_data_r,    out_data_nxt;

  // Shared span unit
  logic [TIME_W-1:0] cmp_from;
  logic [SPAN_W-1:0] cmp_limit;
  logic              cmp_reached;

  logic              in_take;
  logic [SHAPE_W-1:0] fed_shape;
  logic [MASK_W-1:0] mask;
  logic [SHAPE_W-1:0] take_result;
  mode_t             take_mode;
  logic              cand_released;

  ghrg_span_cmp u_span (
    .from_ms  (cmp_from),
    .now_ms   (now_q_r),
    .limit_ms (cmp_limit),
    .reached  (cmp_reached)
  );

  assign in_stall  = (seq_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Qualify the incoming shape: poor quality or an unknown code reads as none.
  always_comb begin
    fed_shape = in_data.shape;
    if ((int'(in_data.shape) >= SHAPE_CODES) || (in_data.score < min_score_r) ||
        (in_data.palm_px < min_palm_r)) begin
      fed_shape = '0;
    end
  end

  // Blocked mask: one bit per tracked shape whose latch is still clear.
  always_comb begin
    mask = '0;
    for (int i = 0; i < NT; i++) begin
      mask[i] = !released_r[i];
    end
  end

  // Steer the shared unit: release timers during feed, then the three
  // take checks in turn.
  always_comb begin
    cmp_from  = absent_since_r[idx_r];
    cmp_limit = release_ms_r;
    if (seq_r == S_TAKE) begin
      case (step_r)
        2'd0: begin
          cmp_from  = state_start_r;
          cmp_limit = settle_ms_r;
        end
        2'd1: begin
          cmp_from  = run_start_r;
          cmp_limit = run_ms_r;
        end
        default: begin
          cmp_from  = held_since_r;
          cmp_limit = long_hold_ms_r;
        end
      endcase
    end
  end

  // Take decision, evaluated on the last step with the long-hold test live.
  assign take_mode     = mode_of(st_q_r);
  assign cand_released = released_r[run_code_r[IDX_W-1:0]];

  always_comb begin
    take_result = '0;
    if ((int'(st_q_r) < STATE_COUNT) && (take_mode != MODE_NONE) && settle_ok_r &&
        (run_code_r != '0) && (run_len_r >= run_results_r) && run_ok_r) begin
      if (take_mode == MODE_THROW) begin
        take_result = run_code_r;
      end else if (cand_released) begin
        take_result = run_code_r;
      end else if (LONG_HOLD_STATES[st_q_r] && (run_code_r == thumbs_up_r) &&
                   (held_code_r == thumbs_up_r) && cmp_reached) begin
        take_result = run_code_r;
      end
    end
  end

  always_comb begin
    min_score_nxt    = min_score_r;
    min_palm_nxt     = min_palm_r;
    release_ms_nxt   = release_ms_r;
    settle_ms_nxt    = settle_ms_r;
    run_ms_nxt       = run_ms_r;
    run_results_nxt  = run_results_r;
    long_hold_ms_nxt = long_hold_ms_r;
    thumbs_up_nxt    = thumbs_up_r;

    state_start_nxt  = state_start_r;
    absent_since_nxt = absent_since_r;
    released_nxt     = released_r;
    held_since_nxt   = held_since_r;
    held_code_nxt    = held_code_r;
    run_code_nxt     = run_code_r;
    run_len_nxt      = run_len_r;
    run_start_nxt    = run_start_r;

    seq_nxt       = seq_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    shape_q_nxt   = shape_q_r;
    st_q_nxt      = st_q_r;
    now_q_nxt     = now_q_r;
    settle_ok_nxt = settle_ok_r;
    run_ok_nxt    = run_ok_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Configuration writes
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_SCORE:    min_score_nxt    = cfg_wdata[7:0];
        REG_MIN_PALM:     min_palm_nxt     = cfg_wdata[9:0];
        REG_RELEASE_MS:   release_ms_nxt   = cfg_wdata;
        REG_SETTLE_MS:    settle_ms_nxt    = cfg_wdata;
        REG_RUN_MS:       run_ms_nxt       = cfg_wdata;
        REG_RUN_RESULTS:  run_results_nxt  = cfg_wdata[7:0];
        REG_LONG_HOLD_MS: long_hold_ms_nxt = cfg_wdata;
        REG_THUMBS_UP:    thumbs_up_nxt    = cfg_wdata[SHAPE_W-1:0];
        default: ;
      endcase
    end

    // Drain the output register when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (seq_r)
      S_IDLE: begin
        if (in_take) begin
          now_q_nxt   = in_data.now_ms;
          st_q_nxt    = in_data.state_index;
          shape_q_nxt = fed_shape;
          idx_nxt     = '0;
          step_nxt    = '0;
          acc_nxt     = '0;
          case (func_t'(in_data.func))
            FUNC_RESTART: begin
              // Clear every timer to now and drop all release latches.
              state_start_nxt = in_data.now_ms;
              for (int i = 0; i < NT; i++) begin
                absent_since_nxt[i] = in_data.now_ms;
              end
              released_nxt   = '0;
              held_since_nxt = in_data.now_ms;
              held_code_nxt  = '0;
              run_code_nxt   = '0;
              run_len_nxt    = '0;
              run_start_nxt  = in_data.now_ms;
              seq_nxt        = S_DONE;
            end
            FUNC_FEED: begin
              // Hold and run trackers do not depend on the timer sweep.
              if ((fed_shape != held_code_r) || (fed_shape == '0)) begin
                held_code_nxt  = fed_shape;
                held_since_nxt = in_data.now_ms;
              end
              if ((fed_shape == '0) || (fed_shape != run_code_r)) begin
                run_code_nxt  = fed_shape;
                run_len_nxt   = (fed_shape == '0) ? 8'd0 : 8'd1;
                run_start_nxt = in_data.now_ms;
              end else if (run_len_r < RUN_LEN_MAX) begin
                run_len_nxt = run_len_r + 8'd1;
              end
              seq_nxt = S_FEED;
            end
            FUNC_TAKE: begin
              seq_nxt = S_TAKE;
            end
            default: begin
              seq_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FEED: begin
        // One release timer per cycle: restart the fed shape, release others whose span is reached.
        if (4'(idx_r) == 4'(shape_q_r)) begin
          absent_since_nxt[idx_r] = now_q_r;
        end else if (!released_r[idx_r] && cmp_reached) begin
          released_nxt[idx_r] = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          seq_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_TAKE: begin
        case (step_r)
          2'd0: begin
            settle_ok_nxt = cmp_reached;
            step_nxt      = 2'd1;
          end
          2'd1: begin
            run_ok_nxt = cmp_reached;
            step_nxt   = 2'd2;
          end
          default: begin
            acc_nxt = take_result;
            seq_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        // Advance once the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = acc_r;
          out_data_nxt.blocked_mask = mask;
          seq_nxt                   = S_IDLE;
        end
      end

      default: begin
        seq_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_score_r    <= 8'd128;
      min_palm_r     <= 10'd40;
      release_ms_r   <= 16'd300;
      settle_ms_r    <= 16'd700;
      run_ms_r       <= 16'd600;
      run_results_r  <= 8'd3;
      long_hold_ms_r <= 16'd2000;
      thumbs_up_r    <= 3'd1;
      state_start_r  <= '0;
      for (int i = 0; i < NT; i++) begin
        absent_since_r[i] <= '0;
      end
      released_r    <= '0;
      held_since_r  <= '0;
      held_code_r   <= '0;
      run_code_r    <= '0;
      run_len_r     <= '0;
      run_start_r   <= '0;
      seq_r         <= S_IDLE;
      idx_r         <= '0;
      step_r        <= '0;
      settle_ok_r   <= 1'b0;
      run_ok_r      <= 1'b0;
      acc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      min_score_r    <= min_score_nxt;
      min_palm_r     <= min_palm_nxt;
      release_ms_r   <= release_ms_nxt;
      settle_ms_r    <= settle_ms_nxt;
      run_ms_r       <= run_ms_nxt;
      run_results_r  <= run_results_nxt;
      long_hold_ms_r <= long_hold_ms_nxt;
      thumbs_up_r    <= thumbs_up_nxt;
      state_start_r  <= state_start_nxt;
      absent_since_r <= absent_since_nxt;
      released_r     <= released_nxt;
      held_since_r   <= held_since_nxt;
      held_code_r    <= held_code_nxt;
      run_code_r     <= run_code_nxt;
      run_len_r      <= run_len_nxt;
      run_start_r    <= run_start_nxt;
      seq_r          <= seq_nxt;
      idx_r          <= idx_nxt;
      step_r         <= step_nxt;
      settle_ok_r    <= settle_ok_nxt;
      run_ok_r       <= run_ok_nxt;
      acc_r          <= acc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    shape_q_r  <= shape_q_nxt;
    st_q_r     <= st_q_nxt;
    now_q_r    <= now_q_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
